// ===== rtl/core/bre_pkg.sv =====
// Shared types, codes and popcount helpers for the bitmap range engine.
// Has no dependencies; bre_word_op, the top level and the testbench import it.
package bre_pkg;

  // Default geometry of the bit store.
  localparam int CAPACITY_BITS_DEF = 4096;
  localparam int WORD_BITS_DEF     = 64;

  // Fixed field widths of the ports.
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 12;
  localparam int CFG_W  = 13;
  localparam int CNT_W  = 13;
  localparam int STAT_W = 2;
  localparam int POP_W  = 7;

  // Request codes.
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FLIP   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FILL   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_EMPTY  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_INVERT = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_REVERSED = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND   = 2'd2;

  // Word operation applied under the span mask.
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_CLR  = 2'd1;
  localparam logic [1:0] OP_FLIP = 2'd2;

  // Popcount constants.
  localparam logic [63:0] POP_M1   = 64'h5555555555555555;
  localparam logic [63:0] POP_M2   = 64'h3333333333333333;
  localparam logic [63:0] POP_M4   = 64'h0f0f0f0f0f0f0f0f;
  localparam logic [6:0]  POP_MASK = 7'h7f;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  start_bit;
    logic [IDX_W-1:0]  stop_bit;
  } in_word_t;

  typedef struct packed {
    logic              bit_value;
    logic [CNT_W-1:0]  set_count;
    logic              every_bit_set;
    logic              every_bit_clear;
    logic [STAT_W-1:0] status;
  } out_word_t;

  // Control of one sweep, handed from the sequencer to the word datapath.
  typedef struct packed {
    logic [1:0] op;
    logic       act;
    logic       cap_en;
  } op_ctrl_t;

  // First half of the popcount: per-byte bit counts.
  function automatic logic [63:0] pop_bytes(input logic [63:0] w);
    logic [63:0] v;
    v = w - ((w >> 1) & POP_M1);
    v = (v & POP_M2) + ((v >> 2) & POP_M2);
    v = (v + (v >> 4)) & POP_M4;
    return v;
  endfunction

  // Second half: fold the eight byte counts into one.
  function automatic logic [POP_W-1:0] byte_sum(input logic [63:0] b);
    logic [63:0] v;
    v = b + (b >> 8);
    v = v + (v >> 16);
    v = v + (v >> 32);
    return v[POP_W-1:0] & POP_MASK;
  endfunction

endpackage

// ===== rtl/core/bre_store.sv =====
// Word store of the bitmap: one write port and one registered read port.
// Depends on nothing but its parameters.
module bre_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bre_word_op.sv =====
// Per-word datapath: span mask, set/clear/flip, bit pick-off and a
// three-stage popcount of the rewritten word. Uses bre_pkg.
module bre_word_op
  import bre_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CMP_W     = 13,
  parameter int LW        = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_v,
  input  logic                 rd_last,
  input  logic [WORD_BITS-1:0] rd_data,
  input  logic [CMP_W-1:0]     base,
  input  op_ctrl_t             ctrl,
  input  logic [CMP_W-1:0]     lo,
  input  logic [CMP_W-1:0]     hi,
  input  logic [CMP_W-1:0]     from,
  output logic                 wr_en,
  output logic [WORD_BITS-1:0] wr_data,
  output logic                 hit_v,
  output logic                 hit_bit,
  output logic                 pc_v,
  output logic                 pc_last,
  output logic [POP_W-1:0]     pc_cnt
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] new_word;
  logic [LW-1:0]        off;
  logic                 in_win;

  logic [WORD_BITS-1:0] nw_r;
  logic [63:0]          bytes_r;
  logic [POP_W-1:0]     pc_r;
  logic                 v1_r, v2_r, v3_r;
  logic                 l1_r, l2_r, l3_r;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = ((base + CMP_W'(j)) >= lo) && ((base + CMP_W'(j)) <= hi);
    end
  end

  always_comb begin
    case (ctrl.op)
      OP_SET:  new_word = rd_data | mask;
      OP_CLR:  new_word = rd_data & ~mask;
      OP_FLIP: new_word = rd_data ^ mask;
      default: new_word = rd_data;
    endcase
  end

  assign wr_en   = rd_v && ctrl.act;
  assign wr_data = ctrl.act ? new_word : rd_data;

  // The requested bit is picked from the word as it was read.
  assign in_win  = (from >= base) && (from < (base + CMP_W'(WORD_BITS)));
  assign off     = LW'(from - base);
  assign hit_v   = rd_v && ctrl.cap_en && in_win;
  assign hit_bit = rd_data[off];

  always_ff @(posedge clk) begin
    nw_r    <= wr_data;
    bytes_r <= pop_bytes(64'(nw_r));
    pc_r    <= byte_sum(bytes_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      l1_r <= 1'b0;
      l2_r <= 1'b0;
      l3_r <= 1'b0;
    end else begin
      v1_r <= rd_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      l1_r <= rd_v && rd_last;
      l2_r <= l1_r;
      l3_r <= l2_r;
    end
  end

  assign pc_v    = v3_r;
  assign pc_last = l3_r;
  assign pc_cnt  = pc_r;

endmodule

// ===== rtl/core/bitmap_range_engine_unit.sv =====
// Bitmap range engine top level: request decode, word sweep sequencer, set-bit count.
// Uses bre_pkg, bre_store and bre_word_op.
//
// Every request, reads included, sweeps all NUM_WORDS words of the store through its single
// read port, one word per cycle, rewriting each word and summing popcounts on the way; the
// next word is taken once the previous result sits in the output register. After reset and
// after every write of bits_in_use the store is cleared by a pass over all NUM_WORDS words
// during which in_ready is low. Bits at or above bits_in_use always read as zero; a write of
// zero is taken as one bit and a value above the capacity as the capacity.
module bitmap_range_engine_unit
  import bre_pkg::*;
#(
  parameter int CAPACITY_BITS = CAPACITY_BITS_DEF,
  parameter int WORD_BITS     = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int NUM_WORDS = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int SPAN_W    = $clog2(NUM_WORDS * WORD_BITS);
  localparam int CMP_W     = ((SPAN_W > CFG_W) ? SPAN_W : CFG_W) + 1;
  localparam int BIU_W     = $clog2(CAPACITY_BITS + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  logic [1:0]       state_r;
  logic [BIU_W-1:0] biu_r;
  logic [BIU_W-1:0] ones_r;
  logic [BIU_W-1:0] ones_nxt;
  logic [BIU_W-1:0] sum_r;
  logic [AW-1:0]    iss_r;
  logic [CMP_W-1:0] base_r;
  logic             issued_r;

  logic             s0_v_r;
  logic             s0_last_r;
  logic [AW-1:0]    s0_addr_r;
  logic [CMP_W-1:0] s0_base_r;

  op_ctrl_t          ctrl_r;
  logic [CMP_W-1:0]  lo_r, hi_r, from_r;
  logic [STAT_W-1:0] status_r;
  logic              before_r;

  out_word_t out_r;
  logic      out_valid_r;

  // Request decode.
  logic [CMP_W-1:0]  from_x, to_x, biu_x, cfg_x;
  logic [STAT_W-1:0] dec_status;
  op_ctrl_t          dec_ctrl;
  logic [CMP_W-1:0]  dec_lo, dec_hi;
  logic [BIU_W-1:0]  cfg_biu;

  // Store and datapath wiring.
  logic                 st_we;
  logic [AW-1:0]        st_waddr;
  logic [WORD_BITS-1:0] st_wdata;
  logic [WORD_BITS-1:0] rd_data;
  logic                 op_wr_en;
  logic [WORD_BITS-1:0] op_wr_data;
  logic                 hit_v, hit_bit;
  logic                 pc_v, pc_last;
  logic [POP_W-1:0]     pc_cnt;
  logic                 accept;
  logic                 out_free;

  assign from_x = CMP_W'(in_data.start_bit);
  assign to_x   = CMP_W'(in_data.stop_bit);
  assign biu_x  = CMP_W'(biu_r);

  always_comb begin
    dec_status    = ST_OK;
    dec_ctrl.act  = 1'b0;
    dec_lo        = from_x;
    dec_hi        = to_x;
    unique case (in_data.func) inside
      FN_SET, FN_CLEAR, FN_FLIP: begin
        if (to_x < from_x) begin
          dec_status = ST_REVERSED;
        end else if (to_x >= biu_x) begin
          dec_status = ST_BEYOND;
        end else begin
          dec_ctrl.act = 1'b1;
        end
      end
      FN_FILL, FN_EMPTY, FN_INVERT: begin
        dec_ctrl.act = 1'b1;
        dec_lo       = '0;
        dec_hi       = biu_x - CMP_W'(1);
      end
      default: begin
        // The read code and the unused code both only read.
        if (from_x >= biu_x) begin
          dec_status = ST_BEYOND;
        end
      end
    endcase
    unique case (in_data.func) inside
      FN_SET, FN_FILL:     dec_ctrl.op = OP_SET;
      FN_CLEAR, FN_EMPTY:  dec_ctrl.op = OP_CLR;
      default:             dec_ctrl.op = OP_FLIP;
    endcase
    dec_ctrl.cap_en = (dec_status == ST_OK) && (from_x < biu_x);
  end

  always_comb begin
    cfg_x = CMP_W'(cfg_wdata);
    if (cfg_x == '0) begin
      cfg_biu = BIU_W'(1);
    end else if (cfg_x > CMP_W'(CAPACITY_BITS)) begin
      cfg_biu = BIU_W'(CAPACITY_BITS);
    end else begin
      cfg_biu = BIU_W'(cfg_x);
    end
  end

  // A register write restarts the clear pass, so no word is taken in that cycle.
  assign in_ready  = (state_r == S_IDLE) && !cfg_we;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign ones_nxt  = ctrl_r.act ? sum_r : ones_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (state_r == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = iss_r;
      st_wdata = '0;
    end else begin
      st_we    = op_wr_en;
      st_waddr = s0_addr_r;
      st_wdata = op_wr_data;
    end
  end

  bre_store #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (iss_r),
    .rdata (rd_data)
  );

  bre_word_op #(
    .WORD_BITS (WORD_BITS),
    .CMP_W     (CMP_W),
    .LW        (LW)
  ) u_word_op (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_v    (s0_v_r),
    .rd_last (s0_last_r),
    .rd_data (rd_data),
    .base    (s0_base_r),
    .ctrl    (ctrl_r),
    .lo      (lo_r),
    .hi      (hi_r),
    .from    (from_r),
    .wr_en   (op_wr_en),
    .wr_data (op_wr_data),
    .hit_v   (hit_v),
    .hit_bit (hit_bit),
    .pc_v    (pc_v),
    .pc_last (pc_last),
    .pc_cnt  (pc_cnt)
  );

  // Request payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_r     <= dec_lo;
      hi_r     <= dec_hi;
      from_r   <= from_x;
      status_r <= dec_status;
    end
    s0_addr_r <= iss_r;
    s0_base_r <= base_r;
    s0_last_r <= (iss_r == LAST_ADDR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      biu_r       <= BIU_W'(CAPACITY_BITS);
      ones_r      <= '0;
      sum_r       <= '0;
      iss_r       <= '0;
      base_r      <= '0;
      issued_r    <= 1'b0;
      s0_v_r      <= 1'b0;
      ctrl_r      <= '0;
      before_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      s0_v_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (hit_v) begin
        before_r <= hit_bit;
      end
      if (pc_v) begin
        sum_r <= sum_r + BIU_W'(pc_cnt);
      end

      if (cfg_we) begin
        biu_r   <= cfg_biu;
        ones_r  <= '0;
        iss_r   <= '0;
        state_r <= S_CLEAR;
      end else begin
        unique case (state_r)
          S_CLEAR: begin
            if (iss_r == LAST_ADDR) begin
              iss_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              iss_r <= iss_r + AW'(1);
            end
          end
          S_IDLE: begin
            if (accept) begin
              ctrl_r   <= dec_ctrl;
              before_r <= 1'b0;
              sum_r    <= '0;
              iss_r    <= '0;
              base_r   <= '0;
              issued_r <= 1'b0;
              state_r  <= S_RUN;
            end
          end
          S_RUN: begin
            if (!issued_r) begin
              s0_v_r <= 1'b1;
              if (iss_r == LAST_ADDR) begin
                issued_r <= 1'b1;
                iss_r    <= '0;
              end else begin
                iss_r  <= iss_r + AW'(1);
                base_r <= base_r + CMP_W'(WORD_BITS);
              end
            end
            if (pc_v && pc_last) begin
              state_r <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_free) begin
              ones_r                <= ones_nxt;
              out_r.bit_value       <= before_r;
              out_r.set_count       <= CNT_W'(ones_nxt);
              out_r.every_bit_set   <= (ones_nxt == biu_r);
              out_r.every_bit_clear <= (ones_nxt == '0);
              out_r.status          <= status_r;
              out_valid_r           <= 1'b1;
              state_r               <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== dv/tb_bitmap_range_engine_unit.sv =====
// Self-checking testbench for bitmap_range_engine_unit: directed and random request words
// under random flow control, checked against a bit-level shadow of the bitmap.
// Depends on bre_pkg and the bitmap_range_engine_unit RTL.
module tb_bitmap_range_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bre_pkg::*;

  localparam int CAP_BITS    = CAPACITY_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int IN_W        = $bits(in_word_t);
  localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Shadow of the bitmap and its configured size.
  bit [CAP_BITS-1:0] shadow_bits   = '0;
  int unsigned       shadow_in_use = CAP_BITS;

  out_word_t expected_words[$];
  int        error_count  = 0;
  int        idle_cycles  = 0;

  // Flow-control knobs shared by the sender, the receiver and the tests.
  bit sender_gaps_on = 1'b1;
  int burst_left     = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;
  int mode_left      = 0;
  int ready_mode     = 0;

  bitmap_range_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_word_t predict_response(input in_word_t req);
    out_word_t         rsp;
    logic [STAT_W-1:0] st;
    int unsigned       lo, hi, f, t, cnt;
    bit                act;
    bit                prior;
    st    = ST_OK;
    act   = 1'b0;
    lo    = 0;
    hi    = 0;
    prior = 1'b0;
    f     = 32'(req.start_bit);
    t     = 32'(req.stop_bit);
    if (req.func == FN_SET || req.func == FN_CLEAR || req.func == FN_FLIP) begin
      // The reversed check takes priority over the size check.
      if (t < f) begin
        st = ST_REVERSED;
      end else if (t >= shadow_in_use) begin
        st = ST_BEYOND;
      end else begin
        lo  = f;
        hi  = t;
        act = 1'b1;
      end
    end else if (req.func == FN_FILL || req.func == FN_EMPTY || req.func == FN_INVERT) begin
      lo  = 0;
      hi  = shadow_in_use - 1;
      act = 1'b1;
    end else if (f >= shadow_in_use) begin
      st = ST_BEYOND;
    end
    if (st == ST_OK && f < shadow_in_use) prior = shadow_bits[f];
    if (act) begin
      for (int i = lo; i <= hi; i++) begin
        case (req.func) inside
          FN_SET, FN_FILL:    shadow_bits[i] = 1'b1;
          FN_CLEAR, FN_EMPTY: shadow_bits[i] = 1'b0;
          default:            shadow_bits[i] = ~shadow_bits[i];
        endcase
      end
    end
    cnt                 = $countones(shadow_bits);
    rsp.bit_value       = prior;
    rsp.set_count       = CNT_W'(cnt);
    rsp.every_bit_set   = (cnt == shadow_in_use);
    rsp.every_bit_clear = (cnt == 0);
    rsp.status          = st;
    return rsp;
  endfunction

  task automatic compare_word(input out_word_t want, input out_word_t got);
    if (got.bit_value !== want.bit_value) begin
      $error("bit_value: expected %0d, actual %0d", want.bit_value, got.bit_value);
      error_count++;
    end
    if (got.set_count !== want.set_count) begin
      $error("set_count: expected %0d, actual %0d", want.set_count, got.set_count);
      error_count++;
    end
    if (got.every_bit_set !== want.every_bit_set) begin
      $error("every_bit_set: expected %0d, actual %0d", want.every_bit_set, got.every_bit_set);
      error_count++;
    end
    if (got.every_bit_clear !== want.every_bit_clear) begin
      $error("every_bit_clear: expected %0d, actual %0d", want.every_bit_clear,
             got.every_bit_clear);
      error_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      error_count++;
    end
  endtask

  // Both handshakes are seen at the rising edge; requests are predicted in acceptance order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_words.push_back(predict_response(in_data));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with no request pending");
          error_count++;
        end else begin
          compare_word(expected_words.pop_front(), out_data);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("bitmap_range_engine_unit regression: fail");
    $finish;
  end

  // Receiver: random ready modes, with a long hold-off whenever a test asks for one.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(16, 200);
        ready_mode = $urandom_range(0, 3);
      end
      mode_left--;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  function automatic in_word_t make_word(input logic [FUNC_W-1:0] func, input int from_i,
                                         input int to_i);
    in_word_t w;
    w.func      = func;
    w.start_bit = IDX_W'(from_i);
    w.stop_bit  = IDX_W'(to_i);
    return w;
  endfunction

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_word(input in_word_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // Only called with the engine idle; the shadow follows the register's clamping.
  task automatic write_bits_in_use(input int unsigned value);
    logic [CFG_W-1:0] v;
    v = CFG_W'(value);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (v == 0) shadow_in_use = 1;
    else if (v > CAP_BITS) shadow_in_use = CAP_BITS;
    else shadow_in_use = 32'(v);
    shadow_bits = '0;
  endtask

  function automatic in_word_t make_request();
    in_word_t    r;
    int unsigned pick, top, span, from_i, to_i;
    top  = shadow_in_use - 1;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r = in_word_t'(IN_W'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 25) r.func = FN_SET;
      else if (pick < 45) r.func = FN_CLEAR;
      else if (pick < 65) r.func = FN_FLIP;
      else if (pick < 85) r.func = FN_READ;
      else if (pick < 90) r.func = FN_FILL;
      else if (pick < 94) r.func = FN_EMPTY;
      else if (pick < 98) r.func = FN_INVERT;
      else r.func = FN_SPARE;
      from_i = $urandom_range(0, top);
      span   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 70) : $urandom_range(0, top);
      to_i   = (from_i + span > top) ? top : from_i + span;
      pick   = $urandom_range(0, 99);
      // A few broken ranges: reversed, or running past the bits in use.
      if (pick < 5 && from_i != to_i) begin
        span   = from_i;
        from_i = to_i;
        to_i   = span;
      end else if (pick < 10 && shadow_in_use < CAP_BITS) begin
        to_i = $urandom_range(shadow_in_use, CAP_BITS - 1);
      end
      r.start_bit = IDX_W'(from_i);
      r.stop_bit  = IDX_W'(to_i);
    end
    return r;
  endfunction

  task automatic test_reset_state();
    send_word(make_word(FN_READ, 0, 0));
    send_word(make_word(FN_READ, CAP_BITS - 1, 0));
  endtask

  task automatic test_range_ops();
    send_word(make_word(FN_SET, 0, CAP_BITS - 1));
    send_word(make_word(FN_CLEAR, CAP_BITS - 1, CAP_BITS - 1));
    send_word(make_word(FN_FLIP, 0, CAP_BITS - 1));
    send_word(make_word(FN_FLIP, 64, 127));
    send_word(make_word(FN_SPARE, CAP_BITS - 1, 5));
    send_word(make_word(FN_SET, 10, 5));
    send_word(make_word(FN_CLEAR, CAP_BITS - 1, 0));
    wait_drain();
    write_bits_in_use(100);
    send_word(make_word(FN_SET, 0, 100));
    send_word(make_word(FN_FLIP, 99, 99));
    send_word(make_word(FN_READ, 100, 0));
    send_word(make_word(FN_SET, 50, CAP_BITS - 1));
  endtask

  // Whole-array words ignore the stop bit and answer even with the start bit out of use.
  task automatic test_whole_array();
    send_word(make_word(FN_FILL, CAP_BITS - 1, 0));
    send_word(make_word(FN_INVERT, 0, 7));
    send_word(make_word(FN_FILL, 3, CAP_BITS - 1));
    send_word(make_word(FN_EMPTY, 99, 0));
    send_word(make_word(FN_INVERT, 200, 1));
  endtask

  task automatic test_config_extremes();
    wait_drain();
    write_bits_in_use(0);
    send_word(make_word(FN_SET, 0, 0));
    send_word(make_word(FN_READ, 1, 0));
    send_word(make_word(FN_FLIP, 0, 0));
    wait_drain();
    write_bits_in_use((1 << CFG_W) - 1);
    send_word(make_word(FN_FILL, 0, 0));
    send_word(make_word(FN_READ, CAP_BITS - 1, 0));
    send_word(make_word(FN_EMPTY, CAP_BITS - 1, 0));
  endtask

  // Results are held back while the sender keeps offering words, so the input stalls.
  task automatic test_full_backpressure();
    wait_drain();
    hold_request   = 1'b1;
    sender_gaps_on = 1'b0;
    repeat (12) send_word(make_request());
    sender_gaps_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_settings();
    int unsigned settings[10];
    settings = '{CAP_BITS, 1, 64, 65, (1 << CFG_W) - 1, 0, $urandom_range(2, CAP_BITS - 1),
                 $urandom_range(CAP_BITS + 1, (1 << CFG_W) - 1), $urandom_range(2, 300), 127};
    foreach (settings[p]) begin
      wait_drain();
      write_bits_in_use(settings[p]);
      sender_gaps_on = (p % 3 != 2);
      repeat (130) send_word(make_request());
    end
    sender_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_range_ops();
    test_whole_array();
    test_config_extremes();
    test_full_backpressure();
    test_random_settings();
    wait_drain();
    repeat (150) @(negedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("bitmap_range_engine_unit regression: pass");
    end else begin
      $display("bitmap_range_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== bitmap_range_engine_unit.f =====
rtl/core/bre_pkg.sv
rtl/core/bre_store.sv
rtl/core/bre_word_op.sv
rtl/core/bitmap_range_engine_unit.sv
dv/tb_bitmap_range_engine_unit.sv
